@@ sv/skt_pkg.sv @@
// Shared types and codes for the sorted key table.
`default_nettype none

package skt_pkg;

  // Fixed widths of the command and result beat fields
  localparam int CMD_W = 3;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int IDX_W = 7;
  localparam int CNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_FIND_EXACT = 3'd1,
    CMD_FIND_FIRST = 3'd2,
    CMD_FIND_LAST  = 3'd3,
    CMD_REMOVE_AT  = 3'd4,
    CMD_GET        = 3'd5
  } skt_cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_MISS      = 2'd1,
    STS_FULL      = 2'd2,
    STS_BAD_INDEX = 2'd3
  } skt_status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_RESULT
  } skt_state_t;

  // Which one-hot flag a cell raises for the result select
  typedef enum logic [1:0] {
    SEL_LOWER,
    SEL_LAST,
    SEL_POS
  } skt_sel_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] entry_value;
    logic [POS_W-1:0] position;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] found_index;
    logic [KEY_W-1:0] found_key;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] entry_count;
  } skt_out_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             ins_en;
    logic             rem_en;
    logic             hit;
    skt_sel_t         sel_mode;
    logic [POS_W-1:0] position;
  } skt_ctrl_t;

endpackage

`default_nettype wire

@@ sv/skt_cell.sv @@
// One table slot: holds an entry, compares it and shifts it to or from its neighbours.
`default_nettype none

module skt_cell #(
  parameter int IDX        = 0,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  skt_pkg::skt_ctrl_t    ctrl,
  input  logic                  valid,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [KEY_BITS-1:0]   new_key,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic                  prev_lt,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  input  logic                  next_lt,
  input  logic                  next_eq,
  output logic                  lt,
  output logic                  eq,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  sel
);
  import skt_pkg::*;

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  lt_r, eq_r;
  logic                  lower_sel;
  logic                  last_sel;
  logic                  at_pos;
  logic                  from_pos;

  // Capture compare flags on the accepted beat, move entry data every cycle
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r <= valid && (key_r < cmp_key);
      eq_r <= valid && (key_r == cmp_key);
    end
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  // Local boundary flags from own and neighbour compare results
  always_comb begin
    lower_sel = !lt_r && prev_lt;
    last_sel  = ctrl.hit ? (eq_r && !next_eq) : (lt_r && !next_lt);
    at_pos    = (int'(ctrl.position) == IDX);
    from_pos  = (IDX >= int'(ctrl.position));
  end

  // Hold, take the new entry, shift up from below or down from above
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.ins_en) begin
      if (lt_r) begin
        key_nxt   = key_r;
        value_nxt = value_r;
      end else if (lower_sel) begin
        key_nxt   = new_key;
        value_nxt = new_value;
      end else begin
        key_nxt   = prev_key;
        value_nxt = prev_value;
      end
    end else if (ctrl.rem_en && from_pos) begin
      key_nxt   = next_key;
      value_nxt = next_value;
    end
  end

  // Raise the select flag for the result mux
  always_comb begin
    case (ctrl.sel_mode)
      SEL_LOWER: sel = lower_sel;
      SEL_LAST:  sel = last_sel;
      SEL_POS:   sel = at_pos;
      default:   sel = 1'b0;
    endcase
  end

  assign lt    = lt_r;
  assign eq    = eq_r;
  assign key   = key_r;
  assign value = value_r;

endmodule

`default_nettype wire

@@ sv/sorted_key_table_top.sv @@
// Sorted key/value table built from a chain of compare-and-shift cells.
// The accepted command and the cell compare flags are registered first; the result beat is registered from them.
// A new command is accepted only while busy is low; busy is high in the cycle after acceptance,
// while the one-hot result select and the shift act on the registered compare flags.
// Reset: synchronous active-low, empties the table (entry count zero); stored data is not cleared.
// The result beat is shown for one cycle and cannot be stalled.
`default_nettype none

module sorted_key_table_top #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  skt_pkg::skt_in_t  in_item,
  output logic              out_valid,
  output skt_pkg::skt_out_t out_item
);
  import skt_pkg::*;

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

  skt_state_t            state_r, state_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [POS_W-1:0]      pos_r;
  logic                  out_valid_r;
  skt_out_t              out_item_r, out_item_nxt;

  logic                  accept;
  logic [KEY_BITS+KEY_W-1:0]   in_key_ext;
  logic [VALUE_BITS+VAL_W-1:0] in_value_ext;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;

  skt_ctrl_t             ctrl;
  logic [CAPACITY-1:0]   valid_v, lt_v, eq_v, sel_v;
  logic [KEY_BITS-1:0]   key_a   [CAPACITY];
  logic [VALUE_BITS-1:0] value_a [CAPACITY];

  logic                  full;
  logic                  pos_ok;
  logic                  any_sel;
  logic [FILL_W-1:0]     sel_idx;
  logic [FILL_W-1:0]     lb_idx;
  logic [KEY_BITS-1:0]   sel_key;
  logic [VALUE_BITS-1:0] sel_value;

  // Fit incoming beat fields to the stored widths
  assign accept       = start && !busy;
  assign in_key_ext   = {{KEY_BITS{1'b0}}, in_item.key};
  assign in_value_ext = {{VALUE_BITS{1'b0}}, in_item.entry_value};
  assign in_key       = in_key_ext[KEY_BITS-1:0];
  assign in_value     = in_value_ext[VALUE_BITS-1:0];

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= (state_r == FSM_RESULT);
    end
  end

  // Hold the accepted command and the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_item.cmd;
      key_r   <= in_key;
      value_r <= in_value;
      pos_r   <= in_item.position;
    end
    if (state_r == FSM_RESULT) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:   if (accept) state_nxt = FSM_RESULT;
      FSM_RESULT: state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  assign busy = (state_r == FSM_RESULT);

  assign full   = (fill_r == FILL_W'(CAPACITY));
  assign pos_ok = (CMP_W'(pos_r) < CMP_W'(fill_r));

  // Broadcast control to the cells
  always_comb begin
    ctrl.cmp_en   = accept;
    ctrl.ins_en   = busy && (cmd_r == CMD_INSERT) && !full;
    ctrl.rem_en   = busy && (cmd_r == CMD_REMOVE_AT) && pos_ok;
    ctrl.hit      = |eq_v;
    ctrl.position = pos_r;
    unique case (cmd_r) inside
      CMD_FIND_LAST:          ctrl.sel_mode = SEL_LAST;
      CMD_REMOVE_AT, CMD_GET: ctrl.sel_mode = SEL_POS;
      default:                ctrl.sel_mode = SEL_LOWER;
    endcase
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]   prev_key, next_key;
    logic [VALUE_BITS-1:0] prev_value, next_value;
    logic                  prev_lt, next_lt, next_eq;

    assign valid_v[i] = (FILL_W'(i) < fill_r);

    if (i == 0) begin : g_first
      assign prev_key   = '0;
      assign prev_value = '0;
      assign prev_lt    = 1'b1;
    end else begin : g_mid_lo
      assign prev_key   = key_a[i-1];
      assign prev_value = value_a[i-1];
      assign prev_lt    = lt_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key   = key_a[i];
      assign next_value = value_a[i];
      assign next_lt    = 1'b0;
      assign next_eq    = 1'b0;
    end else begin : g_mid_hi
      assign next_key   = key_a[i+1];
      assign next_value = value_a[i+1];
      assign next_lt    = lt_v[i+1];
      assign next_eq    = eq_v[i+1];
    end

    skt_cell #(
      .IDX        (i),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valid_v[i]),
      .cmp_key    (in_key),
      .new_key    (key_r),
      .new_value  (value_r),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .prev_lt    (prev_lt),
      .next_key   (next_key),
      .next_value (next_value),
      .next_lt    (next_lt),
      .next_eq    (next_eq),
      .lt         (lt_v[i]),
      .eq         (eq_v[i]),
      .key        (key_a[i]),
      .value      (value_a[i]),
      .sel        (sel_v[i])
    );
  end

  // One-hot select of the chosen cell's index and entry
  always_comb begin
    sel_idx   = '0;
    sel_key   = '0;
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_v[i]) begin
        sel_idx   = sel_idx | FILL_W'(i);
        sel_key   = sel_key | key_a[i];
        sel_value = sel_value | value_a[i];
      end
    end
    any_sel = |sel_v;
    lb_idx  = any_sel ? sel_idx : FILL_W'(CAPACITY);
  end

  // Build the result beat and the next entry count
  always_comb begin
    logic [1:0]              status;
    logic [IDX_W-1:0]        idx;
    logic [KEY_BITS-1:0]     rk;
    logic [VALUE_BITS-1:0]   rv;
    logic [KEY_BITS+KEY_W-1:0]   rk_ext;
    logic [VALUE_BITS+VAL_W-1:0] rv_ext;

    status   = STS_BAD_INDEX;
    idx      = '0;
    rk       = sel_key;
    rv       = sel_value;
    fill_nxt = fill_r;

    unique case (cmd_r)
      CMD_INSERT: begin
        idx = IDX_W'(lb_idx);
        rk  = key_r;
        rv  = value_r;
        if (full) begin
          status = STS_FULL;
        end else begin
          status = STS_OK;
          if (busy) fill_nxt = fill_r + FILL_W'(1);
        end
      end
      CMD_FIND_EXACT: begin
        idx    = IDX_W'(lb_idx);
        status = ctrl.hit ? STS_OK : STS_MISS;
      end
      CMD_FIND_FIRST: begin
        idx    = IDX_W'(lb_idx);
        status = (lb_idx < fill_r) ? STS_OK : STS_MISS;
      end
      CMD_FIND_LAST: begin
        if (ctrl.hit || lt_v[0]) begin
          idx    = IDX_W'(sel_idx);
          status = STS_OK;
        end else begin
          idx    = '0;
          status = STS_MISS;
        end
      end
      CMD_REMOVE_AT: begin
        idx = IDX_W'(pos_r);
        if (pos_ok) begin
          status = STS_OK;
          if (busy) fill_nxt = fill_r - FILL_W'(1);
        end else begin
          status = STS_BAD_INDEX;
        end
      end
      CMD_GET: begin
        idx    = IDX_W'(pos_r);
        status = pos_ok ? STS_OK : STS_BAD_INDEX;
      end
      default: begin
        status = STS_BAD_INDEX;
        idx    = '0;
      end
    endcase

    // Drop entry data unless the command returns an entry
    if (status != STS_OK) begin
      rk = '0;
      rv = '0;
    end
    rk_ext = {{KEY_W{1'b0}}, rk};
    rv_ext = {{VAL_W{1'b0}}, rv};

    out_item_nxt.status      = status;
    out_item_nxt.found_index = idx;
    out_item_nxt.found_key   = rk_ext[KEY_W-1:0];
    out_item_nxt.found_value = rv_ext[VAL_W-1:0];
    out_item_nxt.entry_count = CNT_W'(fill_nxt);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ verif/skt_checker.sv @@
// Scoreboard for the sorted key table: watches both channels, predicts each result and compares.
`default_nettype none

module skt_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  skt_pkg::skt_in_t  in_item,
  input  logic              out_valid,
  input  skt_pkg::skt_out_t out_item,
  output int                pending,
  output int                table_fill,
  output int                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int DEPTH        = 64;
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the table contents
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [VAL_W-1:0] shadow_vals [DEPTH];
  int unsigned      shadow_fill = 0;

  skt_out_t result_q [$];
  int       faults = 0;

  assign fail_count = faults;

  // Run one command against the shadow table and return the beat it should give
  function automatic skt_out_t apply_command(input skt_in_t beat);
    skt_out_t    res;
    int unsigned lb;
    int unsigned idx;
    int unsigned pos;
    bit          hit;
    res = '0;
    pos = beat.position;
    lb  = 0;
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_keys[i] < beat.key) lb++;
    end
    hit = (lb < shadow_fill) && (shadow_keys[lb] == beat.key);
    res.status = STS_BAD_INDEX;
    case (beat.cmd)
      CMD_INSERT: begin
        res.found_index = IDX_W'(lb);
        if (shadow_fill >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          // shift the tail up by one to open the slot
          for (int i = shadow_fill; i > lb; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_keys[lb] = beat.key;
          shadow_vals[lb] = beat.entry_value;
          shadow_fill++;
          res.status      = STS_OK;
          res.found_key   = beat.key;
          res.found_value = beat.entry_value;
        end
      end
      CMD_FIND_EXACT: begin
        res.found_index = IDX_W'(lb);
        if (hit) begin
          res.status      = STS_OK;
          res.found_key   = shadow_keys[lb];
          res.found_value = shadow_vals[lb];
        end else begin
          res.status = STS_MISS;
        end
      end
      CMD_FIND_FIRST: begin
        res.found_index = IDX_W'(lb);
        if (lb < shadow_fill) begin
          res.status      = STS_OK;
          res.found_key   = shadow_keys[lb];
          res.found_value = shadow_vals[lb];
        end else begin
          res.status = STS_MISS;
        end
      end
      CMD_FIND_LAST: begin
        if (hit) begin
          // walk to the last duplicate
          idx = lb;
          while (idx + 1 < shadow_fill && shadow_keys[idx+1] == beat.key) idx++;
        end else begin
          idx = (lb > 0) ? lb - 1 : 0;
        end
        res.found_index = IDX_W'(idx);
        if (hit || lb > 0) begin
          res.status      = STS_OK;
          res.found_key   = shadow_keys[idx];
          res.found_value = shadow_vals[idx];
        end else begin
          res.status = STS_MISS;
        end
      end
      CMD_REMOVE_AT: begin
        res.found_index = IDX_W'(pos);
        if (pos < shadow_fill) begin
          res.status      = STS_OK;
          res.found_key   = shadow_keys[pos];
          res.found_value = shadow_vals[pos];
          // close the gap
          for (int i = pos; i + 1 < shadow_fill; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          shadow_fill--;
        end
      end
      CMD_GET: begin
        res.found_index = IDX_W'(pos);
        if (pos < shadow_fill) begin
          res.status      = STS_OK;
          res.found_key   = shadow_keys[pos];
          res.found_value = shadow_vals[pos];
        end
      end
      default: begin
        res.status      = STS_BAD_INDEX;
        res.found_index = '0;
      end
    endcase
    res.entry_count = CNT_W'(shadow_fill);
    return res;
  endfunction

  task automatic log_fault(input string what, input skt_out_t want, input skt_out_t got);
    faults++;
    if (faults <= REPORT_LIMIT) begin
      $display("%0t %s: expected sts=%0d idx=%0d key=%h val=%h cnt=%0d",
               $realtime, what, want.status, want.found_index, want.found_key,
               want.found_value, want.entry_count);
      $display("    got sts=%0d idx=%0d key=%h val=%h cnt=%0d",
               got.status, got.found_index, got.found_key, got.found_value,
               got.entry_count);
    end
  endtask

  // Check result beats against the oldest prediction, then queue a prediction per accepted beat
  always @(posedge clk) begin : watch
    skt_out_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      result_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (result_q.size() == 0) begin
          log_fault("result beat with nothing outstanding", '0, out_item);
        end else begin
          want = result_q.pop_front();
          if (want.status      !== out_item.status      ||
              want.found_index !== out_item.found_index ||
              want.found_key   !== out_item.found_key   ||
              want.found_value !== out_item.found_value ||
              want.entry_count !== out_item.entry_count) begin
            log_fault("result mismatch", want, out_item);
          end
        end
      end
      if (start && !busy) result_q.push_back(apply_command(in_item));
    end
    pending    <= result_q.size();
    table_fill <= shadow_fill;
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Top of the sorted key table testbench: clock, reset, command stimulus and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  // Command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_UNDEF_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_B = 3'd7;
  localparam int SETTLE_CYCLES = 16;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  logic     out_valid;
  skt_in_t  in_item;
  skt_out_t out_item;
  int       pending;
  int       model_fill;
  int       fail_count;
  bit       no_idle;
  logic [KEY_W-1:0] key_pool [8];

  sorted_key_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  skt_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .pending    (pending),
    .table_fill (model_fill),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("sorted_key_table_top verification failed");
    $finish;
  end

  function automatic skt_in_t make_beat(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v, input logic [POS_W-1:0] p);
    skt_in_t beat;
    beat.cmd         = op;
    beat.key         = k;
    beat.entry_value = v;
    beat.position    = p;
    return beat;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int ins_pct, input int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return CMD_INSERT;
    if (r < ins_pct + rem_pct) return CMD_REMOVE_AT;
    if (r < ins_pct + rem_pct + 2) return $urandom_range(0, 1) ? CMD_UNDEF_A : CMD_UNDEF_B;
    case ($urandom_range(0, 3))
      0:       return CMD_FIND_EXACT;
      1:       return CMD_FIND_FIRST;
      2:       return CMD_FIND_LAST;
      default: return CMD_GET;
    endcase
  endfunction

  // Favour a small pool of keys and their neighbours so duplicates and hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return key_pool[$urandom_range(0, 7)];
    if (r < 7) return $urandom_range(0, 1) ? key_pool[$urandom_range(0, 7)] + 32'd1
                                           : key_pool[$urandom_range(0, 7)] - 32'd1;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (model_fill > 0 && $urandom_range(0, 3) != 0) begin
      return POS_W'($urandom_range(0, model_fill - 1));
    end
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Hold the beat until accepted, then idle for a while with noise on the payload
  task automatic send_cmd(input skt_in_t beat);
    int gap;
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      start   <= 1'b0;
      in_item <= make_beat(CMD_W'($urandom), $urandom, $urandom, POS_W'($urandom));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int ins_pct, input int rem_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_cmd(make_beat(pick_cmd(ins_pct, rem_pct), pick_key(), $urandom, pick_pos()));
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    no_idle = 1'b0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Lookups, reads and removes on an empty table
    send_cmd(make_beat(CMD_FIND_EXACT, 32'h1234_5678, $urandom, '0));
    send_cmd(make_beat(CMD_FIND_FIRST, 32'h0000_0000, $urandom, '0));
    send_cmd(make_beat(CMD_FIND_LAST,  32'hFFFF_FFFF, $urandom, '0));
    send_cmd(make_beat(CMD_GET,        $urandom, $urandom, 6'd0));
    send_cmd(make_beat(CMD_REMOVE_AT,  $urandom, $urandom, 6'd63));
    // Extreme keys and a run of duplicates
    send_cmd(make_beat(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, '0));
    send_cmd(make_beat(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, '1));
    send_cmd(make_beat(CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, '0));
    send_cmd(make_beat(CMD_INSERT, 32'h8000_0000, 32'h0000_0001, '0));
    send_cmd(make_beat(CMD_INSERT, 32'h8000_0000, 32'h0000_0002, '0));
    send_cmd(make_beat(CMD_FIND_EXACT, 32'h8000_0000, $urandom, '0));
    send_cmd(make_beat(CMD_FIND_LAST,  32'h8000_0000, $urandom, '0));
    // Misses: next entry, entry before the insertion point, insertion point
    send_cmd(make_beat(CMD_FIND_FIRST, 32'h7FFF_FFFF, $urandom, '0));
    send_cmd(make_beat(CMD_FIND_LAST,  32'h7FFF_FFFF, $urandom, '0));
    send_cmd(make_beat(CMD_FIND_EXACT, 32'h7FFF_FFFF, $urandom, '0));
    send_cmd(make_beat(CMD_GET,        $urandom, $urandom, 6'd4));
    send_cmd(make_beat(CMD_REMOVE_AT,  $urandom, $urandom, 6'd4));
    // Nothing at or after the key once the top entry is gone
    send_cmd(make_beat(CMD_FIND_FIRST, 32'hFFFF_FFFF, $urandom, '0));
    send_cmd(make_beat(CMD_GET,        $urandom, $urandom, 6'd63));
    send_cmd(make_beat(CMD_REMOVE_AT,  $urandom, $urandom, 6'd0));
    // No entry before the insertion point
    send_cmd(make_beat(CMD_FIND_LAST,  32'h0000_0000, $urandom, '0));
    send_cmd(make_beat(CMD_UNDEF_A,    $urandom, $urandom, POS_W'($urandom)));
    send_cmd(make_beat(CMD_UNDEF_B,    $urandom, $urandom, POS_W'($urandom)));
    send_cmd(make_beat(CMD_GET,        $urandom, $urandom, 6'd3));

    // Fill to capacity and keep pushing inserts into the full table
    run_phase(160, 85, 5);
    settle();
    run_phase(240, 35, 30);
    // Drain to empty, then mixed traffic again
    run_phase(160, 10, 75);
    settle();
    run_phase(240, 40, 25);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_key_table_top verification clean");
    end else begin
      $display("sorted_key_table_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
